FILE: rtl/udpfr_pkg.sv
// ----------------------------------------------------------------------------
// udpfr_pkg
// Shared types and constants for the UDP/IPv4/Ethernet frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package udpfr_pkg;

  // field widths
  localparam int LEN_W   = 11;
  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 48;
  localparam int CADDR_W = 3;

  // header layout
  localparam int HDR_BYTES = 43;
  localparam int IDX_W     = 6;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_BYTES - 1);
  localparam logic [ADDR_W-1:0] HDR_TAIL = ADDR_W'(HDR_BYTES - 1);

  // header constants
  localparam logic [7:0]  CTRL_BYTE   = 8'h0E;
  localparam logic [7:0]  ETYPE_HI    = 8'h08;
  localparam logic [7:0]  ETYPE_LO    = 8'h00;
  localparam logic [7:0]  IP_VER_IHL  = 8'h45;
  localparam logic [7:0]  IP_TTL      = 8'h40;
  localparam logic [7:0]  IP_PROTO    = 8'h11;
  localparam logic [15:0] IP_HDR_LEN  = 16'd28;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  // sum of the fixed nonzero ip header words 0x4500 and 0x4011
  localparam logic [15:0] CSUM_FIXED  = 16'h8511;
  localparam int CSUM_W = 19;

  // input kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // configuration register indexes
  localparam logic [CADDR_W-1:0] REG_DEST_MAC    = 3'd0;
  localparam logic [CADDR_W-1:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [CADDR_W-1:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [CADDR_W-1:0] REG_DEST_IP     = 3'd3;
  localparam logic [CADDR_W-1:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [CADDR_W-1:0] REG_DEST_PORT   = 3'd5;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // one queued job: a header burst or a single payload byte
  typedef struct packed {
    logic              is_hdr;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic [ADDR_W-1:0] tx_start;
    logic [ADDR_W-1:0] tx_end;
  } item_t;

  // register file contents seen by the back end
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/udpfr_front.sv
// ----------------------------------------------------------------------------
// udpfr_front
// Accepts input beats, tracks the open frame and queues header or byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfr_front #(
  parameter int MAX_PAYLOAD = 1472,
  parameter int HALF_SIZE   = 2048
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              acc,
  input  wire                              cmd,
  input  wire  [udpfr_pkg::LEN_W-1:0]      payload_len,
  input  wire  [udpfr_pkg::BYTE_W-1:0]     data_byte,
  output logic                             push,
  output udpfr_pkg::item_t                 push_item
);

  localparam logic [udpfr_pkg::LEN_W-1:0] MAX_LEN = udpfr_pkg::LEN_W'(MAX_PAYLOAD);
  localparam logic [udpfr_pkg::ADDR_W-1:0] HALF_ADDR =
    udpfr_pkg::ADDR_W'(HALF_SIZE % (1 << udpfr_pkg::ADDR_W));

  logic                          half_r, half_nxt;
  logic                          open_r, open_nxt;
  logic [udpfr_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic [udpfr_pkg::ADDR_W-1:0]  fstart_r, fstart_nxt;
  logic [udpfr_pkg::ADDR_W-1:0]  fend_r, fend_nxt;

  logic [udpfr_pkg::LEN_W-1:0]   len_sat;
  logic [udpfr_pkg::ADDR_W-1:0]  start_addr;
  logic [udpfr_pkg::LEN_W-1:0]   left_dec;

  // start frame: clamp length and place the frame in the next half
  always_comb begin
    len_sat    = (payload_len > MAX_LEN) ? MAX_LEN : payload_len;
    start_addr = half_r ? HALF_ADDR : '0;
    left_dec   = left_r - udpfr_pkg::LEN_W'(1);
  end

  // classify the beat and build the job
  always_comb begin
    half_nxt   = half_r;
    open_nxt   = open_r;
    left_nxt   = left_r;
    fstart_nxt = fstart_r;
    fend_nxt   = fend_r;
    push       = 1'b0;
    push_item  = '0;
    if (acc) begin
      if (cmd == udpfr_pkg::CMD_START) begin
        half_nxt   = ~half_r;
        fstart_nxt = start_addr;
        fend_nxt   = start_addr + udpfr_pkg::ADDR_W'(len_sat) + udpfr_pkg::HDR_TAIL;
        left_nxt   = len_sat;
        open_nxt   = (len_sat != '0);
        push       = 1'b1;
        push_item.is_hdr   = 1'b1;
        push_item.last     = (len_sat == '0);
        push_item.len      = len_sat;
        push_item.tx_start = fstart_nxt;
        push_item.tx_end   = fend_nxt;
      end else if (open_r) begin
        left_nxt = left_dec;
        open_nxt = (left_dec != '0);
        push     = 1'b1;
        push_item.is_hdr   = 1'b0;
        push_item.last     = (left_dec == '0);
        push_item.data     = data_byte;
        push_item.tx_start = fstart_r;
        push_item.tx_end   = fend_r;
      end
    end
  end

  // frame tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= 1'b0;
      open_r   <= 1'b0;
      left_r   <= '0;
      fstart_r <= '0;
      fend_r   <= '0;
    end else begin
      half_r   <= half_nxt;
      open_r   <= open_nxt;
      left_r   <= left_nxt;
      fstart_r <= fstart_nxt;
      fend_r   <= fend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/udpfr_queue.sv
// ----------------------------------------------------------------------------
// udpfr_queue
// Short job queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfr_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  udpfr_pkg::item_t   push_item,
  input  wire                pop,
  output logic               full,
  output logic               nempty,
  output udpfr_pkg::item_t   head
);

  udpfr_pkg::item_t                mem_r [udpfr_pkg::QDEPTH];
  logic [udpfr_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [udpfr_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [udpfr_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  // status and head view
  always_comb begin
    full   = (cnt_r == udpfr_pkg::QCNT_W'(udpfr_pkg::QDEPTH));
    nempty = (cnt_r != '0);
    head   = mem_r[rd_r];
  end

  // pointer and fill count update
  always_comb begin
    wr_nxt  = push ? wr_r + udpfr_pkg::QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + udpfr_pkg::QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + udpfr_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - udpfr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/udpfr_back.sv
// ----------------------------------------------------------------------------
// udpfr_back
// Byte sequencer: expands header jobs into 43 beats, passes payload bytes,
// and drives the registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfr_back (
  input  wire                               clk,
  input  wire                               rst_n,
  input  udpfr_pkg::cfg_t                   cfg,
  input  wire                               nempty,
  input  udpfr_pkg::item_t                  head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [udpfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                              out_last,
  output logic [udpfr_pkg::ADDR_W-1:0]      out_start,
  output logic [udpfr_pkg::ADDR_W-1:0]      out_end
);

  logic [udpfr_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [udpfr_pkg::CSUM_W-1:0]  cs_r, cs_nxt;
  logic                          vld_r, vld_nxt;
  logic [udpfr_pkg::BYTE_W-1:0]  byte_r;
  logic                          last_r;
  logic [udpfr_pkg::ADDR_W-1:0]  start_r;
  logic [udpfr_pkg::ADDR_W-1:0]  end_r;

  logic                          adv;
  logic                          fire;
  logic [15:0]                   tot_len;
  logic [15:0]                   udp_len;
  logic [15:0]                   ck;
  logic [udpfr_pkg::BYTE_W-1:0]  hbyte;
  logic [udpfr_pkg::BYTE_W-1:0]  beat_byte;
  logic                          beat_last;

  assign adv  = !vld_r || out_ready;
  assign fire = adv && nempty;

  // length fields and finished checksum
  always_comb begin
    tot_len = 16'(head.len) + udpfr_pkg::IP_HDR_LEN;
    udp_len = 16'(head.len) + udpfr_pkg::UDP_HDR_LEN;
    ck      = ~cs_r[15:0];
  end

  // header byte select
  always_comb begin
    case (idx_r)
      6'd0:    hbyte = udpfr_pkg::CTRL_BYTE;
      6'd1:    hbyte = cfg.dest_mac[47:40];
      6'd2:    hbyte = cfg.dest_mac[39:32];
      6'd3:    hbyte = cfg.dest_mac[31:24];
      6'd4:    hbyte = cfg.dest_mac[23:16];
      6'd5:    hbyte = cfg.dest_mac[15:8];
      6'd6:    hbyte = cfg.dest_mac[7:0];
      6'd7:    hbyte = cfg.source_mac[47:40];
      6'd8:    hbyte = cfg.source_mac[39:32];
      6'd9:    hbyte = cfg.source_mac[31:24];
      6'd10:   hbyte = cfg.source_mac[23:16];
      6'd11:   hbyte = cfg.source_mac[15:8];
      6'd12:   hbyte = cfg.source_mac[7:0];
      6'd13:   hbyte = udpfr_pkg::ETYPE_HI;
      6'd14:   hbyte = udpfr_pkg::ETYPE_LO;
      6'd15:   hbyte = udpfr_pkg::IP_VER_IHL;
      6'd17:   hbyte = tot_len[15:8];
      6'd18:   hbyte = tot_len[7:0];
      6'd23:   hbyte = udpfr_pkg::IP_TTL;
      6'd24:   hbyte = udpfr_pkg::IP_PROTO;
      6'd25:   hbyte = ck[15:8];
      6'd26:   hbyte = ck[7:0];
      6'd27:   hbyte = cfg.source_ip[31:24];
      6'd28:   hbyte = cfg.source_ip[23:16];
      6'd29:   hbyte = cfg.source_ip[15:8];
      6'd30:   hbyte = cfg.source_ip[7:0];
      6'd31:   hbyte = cfg.dest_ip[31:24];
      6'd32:   hbyte = cfg.dest_ip[23:16];
      6'd33:   hbyte = cfg.dest_ip[15:8];
      6'd34:   hbyte = cfg.dest_ip[7:0];
      6'd35:   hbyte = cfg.source_port[15:8];
      6'd36:   hbyte = cfg.source_port[7:0];
      6'd37:   hbyte = cfg.dest_port[15:8];
      6'd38:   hbyte = cfg.dest_port[7:0];
      6'd39:   hbyte = udp_len[15:8];
      6'd40:   hbyte = udp_len[7:0];
      default: hbyte = '0;
    endcase
  end

  // ip checksum, built one word per header beat, then folded twice
  always_comb begin
    case (idx_r)
      6'd0:    cs_nxt = udpfr_pkg::CSUM_W'(udpfr_pkg::CSUM_FIXED)
                        + udpfr_pkg::CSUM_W'(tot_len);
      6'd1:    cs_nxt = cs_r + udpfr_pkg::CSUM_W'(cfg.source_ip[31:16]);
      6'd2:    cs_nxt = cs_r + udpfr_pkg::CSUM_W'(cfg.source_ip[15:0]);
      6'd3:    cs_nxt = cs_r + udpfr_pkg::CSUM_W'(cfg.dest_ip[31:16]);
      6'd4:    cs_nxt = cs_r + udpfr_pkg::CSUM_W'(cfg.dest_ip[15:0]);
      6'd5,
      6'd6:    cs_nxt = udpfr_pkg::CSUM_W'(cs_r[15:0])
                        + udpfr_pkg::CSUM_W'(cs_r[udpfr_pkg::CSUM_W-1:16]);
      default: cs_nxt = cs_r;
    endcase
    if (!(fire && head.is_hdr)) begin
      cs_nxt = cs_r;
    end
  end

  // beat contents and job sequencing
  always_comb begin
    beat_byte = head.is_hdr ? hbyte : head.data;
    beat_last = head.is_hdr ? (head.last && (idx_r == udpfr_pkg::IDX_LAST)) : head.last;
    pop       = 1'b0;
    idx_nxt   = idx_r;
    if (fire) begin
      if (!head.is_hdr || idx_r == udpfr_pkg::IDX_LAST) begin
        pop     = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + udpfr_pkg::IDX_W'(1);
      end
    end
    vld_nxt = adv ? nempty : vld_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // checksum accumulator and output payload
  always_ff @(posedge clk) begin
    cs_r <= cs_nxt;
    if (fire) begin
      byte_r  <= beat_byte;
      last_r  <= beat_last;
      start_r <= head.tx_start;
      end_r   <= head.tx_end;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_start = start_r;
  assign out_end   = end_r;

endmodule

`default_nettype wire

FILE: rtl/udp_ipv4_ethernet_framer.sv
// An accepted beat is first written into the job queue; its first output beat is then registered by the back end.
// Throughput: one payload byte per cycle while out_tready is high; a start beat
// produces 43 header beats at one per cycle, set by the single byte sequencer in the back end.
// A four-entry job queue lets input beats keep arriving during a header burst.
// Reset (synchronous, active low) restores the register defaults, closes any
// open frame, empties the queue and points the next frame at address 0.
// ----------------------------------------------------------------------------
// udp_ipv4_ethernet_framer
// Builds UDP/IPv4/Ethernet frames byte by byte for a two-half transmit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_ethernet_framer #(
  parameter int MAX_PAYLOAD = 1472,
  parameter int HALF_SIZE   = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [udpfr_pkg::CADDR_W-1:0]       cfg_addr,
  input  wire  [udpfr_pkg::CFG_W-1:0]         cfg_wdata,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [23:0]                         in_tdata,  // payload_len, data_byte, zero pad
  input  wire                                 in_tuser,  // cmd
  // output stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [31:0]                         out_tdata, // out_byte, tx_start, tx_end
  output logic                                out_tlast
);

  udpfr_pkg::cfg_t   cfg_r;
  udpfr_pkg::item_t  push_item;
  udpfr_pkg::item_t  head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_nempty;
  logic              in_acc;

  logic [udpfr_pkg::BYTE_W-1:0] o_byte;
  logic [udpfr_pkg::ADDR_W-1:0] o_start;
  logic [udpfr_pkg::ADDR_W-1:0] o_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_mac    <= 48'h90E6BAF10A4D;
      cfg_r.source_mac  <= 48'hD6BE7BF2D110;
      cfg_r.source_ip   <= 32'h0A230002;
      cfg_r.dest_ip     <= 32'h0A230001;
      cfg_r.source_port <= 16'd5000;
      cfg_r.dest_port   <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_addr)
        udpfr_pkg::REG_DEST_MAC:    cfg_r.dest_mac    <= cfg_wdata;
        udpfr_pkg::REG_SOURCE_MAC:  cfg_r.source_mac  <= cfg_wdata;
        udpfr_pkg::REG_SOURCE_IP:   cfg_r.source_ip   <= cfg_wdata[31:0];
        udpfr_pkg::REG_DEST_IP:     cfg_r.dest_ip     <= cfg_wdata[31:0];
        udpfr_pkg::REG_SOURCE_PORT: cfg_r.source_port <= cfg_wdata[15:0];
        udpfr_pkg::REG_DEST_PORT:   cfg_r.dest_port   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_tready = ~q_full;
  assign in_acc    = in_tvalid & in_tready;

  udpfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .HALF_SIZE   (HALF_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .cmd         (in_tuser),
    .payload_len (in_tdata[10:0]),
    .data_byte   (in_tdata[18:11]),
    .push        (push),
    .push_item   (push_item)
  );

  udpfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .nempty    (q_nempty),
    .head      (head)
  );

  udpfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .nempty    (q_nempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (o_byte),
    .out_last  (out_tlast),
    .out_start (o_start),
    .out_end   (o_end)
  );

  // output packing
  assign out_tdata = {o_end, o_start, o_byte};

endmodule

`default_nettype wire

FILE: tb/udpfr_checker.sv
// ----------------------------------------------------------------------------
// udpfr_checker
// Watches the configuration port and both streams of the frame builder. It
// keeps its own copy of the registers and the frame state, works out the
// header and payload beats that each accepted input beat should cause, and
// compares every output beat in order against the oldest expected one.
// ----------------------------------------------------------------------------

module udpfr_checker #(
  parameter int MAX_PAYLOAD = 1472,
  parameter int HALF_SIZE   = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [udpfr_pkg::CADDR_W-1:0]   cfg_addr,
  input  logic [udpfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // payload_len, data_byte, zero pad
  input  logic                            in_tuser,   // cmd
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,  // out_byte, tx_start, tx_end
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending_beats
);

  localparam int REPORT_MAX = 10;

  // one output beat as the frame builder should produce it
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic [11:0] start_addr;
    logic [11:0] last_addr;
  } frame_beat_t;

  frame_beat_t expected_beats[$];

  // mirrored registers and frame state
  udpfr_pkg::cfg_t regs;
  logic        half_sel;
  logic        frame_active;
  logic [10:0] bytes_remaining;
  logic [11:0] cur_start;
  logic [11:0] cur_last;
  int          errors;
  int          out_count;

  // ip header checksum over the ten header words, checksum word taken as zero
  function automatic logic [15:0] ip_header_csum(logic [15:0] total_len,
                                                 logic [31:0] sip,
                                                 logic [31:0] dip);
    logic [31:0] acc;
    acc = 32'h4500 + total_len + 32'h4011 + sip[31:16] + sip[15:0]
        + dip[31:16] + dip[15:0];
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  // expected beats for one accepted input beat
  task automatic predict_frame_beats(logic cmd, logic [10:0] len_in, logic [7:0] data);
    logic [7:0]  hdr [udpfr_pkg::HDR_BYTES];
    int          len;
    int          base;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] csum;
    frame_beat_t b;
    if (cmd == udpfr_pkg::CMD_DATA) begin
      if (frame_active) begin
        bytes_remaining = bytes_remaining - 11'd1;
        b.byte_val   = data;
        b.last       = (bytes_remaining == 11'd0);
        b.start_addr = cur_start;
        b.last_addr  = cur_last;
        expected_beats.push_back(b);
        if (bytes_remaining == 11'd0) frame_active = 1'b0;
      end
    end else begin
      len = (int'(len_in) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_in);
      base = half_sel ? HALF_SIZE : 0;
      half_sel = ~half_sel;
      cur_start = 12'(base);
      cur_last  = 12'(base + len + 42);
      ip_len  = 16'(len + 28);
      udp_len = 16'(len + 8);
      csum = ip_header_csum(ip_len, regs.source_ip, regs.dest_ip);
      hdr[0] = udpfr_pkg::CTRL_BYTE;
      for (int i = 0; i < 6; i++) begin
        hdr[1 + i] = regs.dest_mac[47 - 8*i -: 8];
        hdr[7 + i] = regs.source_mac[47 - 8*i -: 8];
      end
      hdr[13] = udpfr_pkg::ETYPE_HI;
      hdr[14] = udpfr_pkg::ETYPE_LO;
      hdr[15] = udpfr_pkg::IP_VER_IHL;
      hdr[16] = 8'h00;
      hdr[17] = ip_len[15:8];
      hdr[18] = ip_len[7:0];
      for (int i = 19; i < 23; i++) hdr[i] = 8'h00;
      hdr[23] = udpfr_pkg::IP_TTL;
      hdr[24] = udpfr_pkg::IP_PROTO;
      hdr[25] = csum[15:8];
      hdr[26] = csum[7:0];
      for (int i = 0; i < 4; i++) begin
        hdr[27 + i] = regs.source_ip[31 - 8*i -: 8];
        hdr[31 + i] = regs.dest_ip[31 - 8*i -: 8];
      end
      hdr[35] = regs.source_port[15:8];
      hdr[36] = regs.source_port[7:0];
      hdr[37] = regs.dest_port[15:8];
      hdr[38] = regs.dest_port[7:0];
      hdr[39] = udp_len[15:8];
      hdr[40] = udp_len[7:0];
      hdr[41] = 8'h00;
      hdr[42] = 8'h00;
      bytes_remaining = 11'(len);
      frame_active = (len != 0);
      for (int i = 0; i < udpfr_pkg::HDR_BYTES; i++) begin
        b.byte_val   = hdr[i];
        b.last       = (i == udpfr_pkg::HDR_BYTES - 1) && (len == 0);
        b.start_addr = cur_start;
        b.last_addr  = cur_last;
        expected_beats.push_back(b);
      end
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin : monitor
    frame_beat_t want;
    logic        bad;
    if (!rst_n) begin
      regs.dest_mac    = 48'h90E6BAF10A4D;
      regs.source_mac  = 48'hD6BE7BF2D110;
      regs.source_ip   = 32'h0A230002;
      regs.dest_ip     = 32'h0A230001;
      regs.source_port = 16'd5000;
      regs.dest_port   = 16'd5000;
      half_sel        = 1'b0;
      frame_active    = 1'b0;
      bytes_remaining = '0;
      cur_start       = '0;
      cur_last        = '0;
      errors          = 0;
      out_count       = 0;
      expected_beats.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          udpfr_pkg::REG_DEST_MAC:    regs.dest_mac    = cfg_wdata[47:0];
          udpfr_pkg::REG_SOURCE_MAC:  regs.source_mac  = cfg_wdata[47:0];
          udpfr_pkg::REG_SOURCE_IP:   regs.source_ip   = cfg_wdata[31:0];
          udpfr_pkg::REG_DEST_IP:     regs.dest_ip     = cfg_wdata[31:0];
          udpfr_pkg::REG_SOURCE_PORT: regs.source_port = cfg_wdata[15:0];
          udpfr_pkg::REG_DEST_PORT:   regs.dest_port   = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // accepted input beat
      if (in_tvalid && in_tready)
        predict_frame_beats(in_tuser, in_tdata[10:0], in_tdata[18:11]);
      // accepted output beat
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("beat %0d: unexpected, got byte %02h last %0b start %03h end %03h",
                     out_count, out_tdata[7:0], out_tlast, out_tdata[19:8],
                     out_tdata[31:20]);
        end else begin
          want = expected_beats.pop_front();
          bad = (out_tdata[7:0] !== want.byte_val) || (out_tlast !== want.last) ||
                (out_tdata[19:8] !== want.start_addr) ||
                (out_tdata[31:20] !== want.last_addr);
          if (bad) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display({"beat %0d differs: expected byte %02h last %0b start %03h end %03h,",
                        " got byte %02h last %0b start %03h end %03h"},
                       out_count, want.byte_val, want.last, want.start_addr,
                       want.last_addr, out_tdata[7:0], out_tlast, out_tdata[19:8],
                       out_tdata[31:20]);
          end
        end
        out_count++;
      end
    end
    fail_count    <= errors;
    pending_beats <= expected_beats.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the frame builder with directed and random frames over several
// register settings, with random gaps and two long output hold-offs, and gives
// the verdict from the failure count that the checker reports.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 50;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [udpfr_pkg::CADDR_W-1:0] cfg_addr   = '0;
  logic [udpfr_pkg::CFG_W-1:0]   cfg_wdata  = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [23:0]                   in_tdata   = '0;   // payload_len, data_byte, zero pad
  logic                          in_tuser   = 1'b0; // cmd
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [31:0]                   out_tdata;         // out_byte, tx_start, tx_end
  logic                          out_tlast;

  int   fail_count;
  int   pending_beats;
  int   cycle_count = 0;
  int   sent_items  = 0;
  logic tx_burst    = 1'b0;

  always #4 clk = ~clk;

  udp_ipv4_ethernet_framer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  udpfr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("udp_ipv4_ethernet_framer: mismatch");
      $finish;
    end
  end

  // offer one input beat after a random gap, return once it is taken
  task automatic send_beat(logic cmd, logic [10:0] len, logic [7:0] data);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, data, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // start beat followed by some payload beats
  task automatic send_frame(logic [10:0] len, int nbytes);
    send_beat(udpfr_pkg::CMD_START, len, 8'($urandom));
    sent_items++;
    for (int i = 0; i < nbytes; i++) begin
      send_beat(udpfr_pkg::CMD_DATA, 11'($urandom), 8'($urandom));
      sent_items++;
    end
  endtask

  // payload beats with no frame open, dropped by the block
  task automatic send_stray(int n);
    for (int i = 0; i < n; i++)
      send_beat(udpfr_pkg::CMD_DATA, 11'($urandom), 8'($urandom));
  endtask

  // stop offering and wait until every expected beat is out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six registers back to back
  task automatic apply_setting(udpfr_pkg::cfg_t s);
    cfg_we <= 1'b1;
    cfg_addr <= udpfr_pkg::REG_DEST_MAC;    cfg_wdata <= s.dest_mac;         @(posedge clk);
    cfg_addr <= udpfr_pkg::REG_SOURCE_MAC;  cfg_wdata <= s.source_mac;       @(posedge clk);
    cfg_addr <= udpfr_pkg::REG_SOURCE_IP;   cfg_wdata <= 48'(s.source_ip);   @(posedge clk);
    cfg_addr <= udpfr_pkg::REG_DEST_IP;     cfg_wdata <= 48'(s.dest_ip);     @(posedge clk);
    cfg_addr <= udpfr_pkg::REG_SOURCE_PORT; cfg_wdata <= 48'(s.source_port); @(posedge clk);
    cfg_addr <= udpfr_pkg::REG_DEST_PORT;   cfg_wdata <= 48'(s.dest_port);   @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random frames, mostly well formed with small payloads
  task automatic run_random_frames(int quota);
    int          goal;
    int          pick;
    int          nbytes;
    logic [10:0] len;
    goal = sent_items + quota;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 3) == 0);
      if (pick < 4)       len = 11'($urandom_range(1473, 2047));
      else if (pick < 8)  len = 11'($urandom_range(1400, 1472));
      else if (pick < 22) len = 11'd0;
      else if (pick < 30) len = 11'($urandom_range(21, 60));
      else                len = 11'($urandom_range(1, 20));
      // large frames are cut short by the next start
      if (len > 11'd60)
        nbytes = $urandom_range(0, 8);
      else if ($urandom_range(0, 9) == 0)
        nbytes = $urandom_range(0, int'(len));
      else
        nbytes = int'(len);
      send_frame(len, nbytes);
      if (nbytes == int'(len) && $urandom_range(0, 7) == 0)
        send_stray($urandom_range(1, 2));
    end
    tx_burst = 1'b0;
  endtask

  // output side: random gaps, bursts, and two long hold-offs
  initial begin : sink
    int   gap;
    int   beats;
    logic rx_burst;
    beats = 0;
    rx_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (beats % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      if (beats == 150 || beats == 1000) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      beats++;
    end
  end

  // stimulus and verdict
  initial begin : source
    udpfr_pkg::cfg_t s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames on the reset registers
    send_frame(11'd2047, 2);            // oversized length, abandoned
    send_frame(11'd1472, 1);            // largest length, abandoned
    send_frame(11'd0, 0);               // empty payload
    send_stray(2);                      // data with no frame open
    send_beat(udpfr_pkg::CMD_START, 11'd1, 8'hFF);
    send_beat(udpfr_pkg::CMD_DATA, 11'h7FF, 8'hFF);
    send_beat(udpfr_pkg::CMD_START, 11'd3, 8'h00);
    send_beat(udpfr_pkg::CMD_DATA, 11'h000, 8'h00);
    send_beat(udpfr_pkg::CMD_DATA, 11'h555, 8'h5A);
    send_beat(udpfr_pkg::CMD_DATA, 11'h2AA, 8'hA5);
    send_stray(1);
    send_frame(11'd1473, 0);            // just over the limit, then restarted
    send_beat(udpfr_pkg::CMD_START, 11'd2, 8'h81);
    send_beat(udpfr_pkg::CMD_DATA, 11'h123, 8'h81);
    send_beat(udpfr_pkg::CMD_DATA, 11'h456, 8'h7E);
    send_frame(11'd0, 0);
    settle();

    // all registers at zero
    s = '0;
    apply_setting(s);
    run_random_frames(PHASE_ITEMS);
    settle();

    // all registers at their maximum
    s = '1;
    apply_setting(s);
    run_random_frames(PHASE_ITEMS);
    settle();

    // two random settings, the last one ending in a longer complete frame
    for (int p = 0; p < 2; p++) begin
      s.dest_mac    = {16'($urandom), 32'($urandom)};
      s.source_mac  = {16'($urandom), 32'($urandom)};
      s.source_ip   = $urandom;
      s.dest_ip     = $urandom;
      s.source_port = 16'($urandom);
      s.dest_port   = 16'($urandom);
      apply_setting(s);
      run_random_frames(PHASE_ITEMS);
      settle();
    end
    send_frame(11'd64, 64);
    send_stray(1);
    settle();

    if (fail_count == 0 && pending_beats == 0)
      $display("udp_ipv4_ethernet_framer: match");
    else
      $display("udp_ipv4_ethernet_framer: mismatch");
    $finish;
  end

endmodule
